// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/sbcr_pkg.sv
package sbcr_pkg;

    localparam int COORD_BITS = 12;
    // Working width: covers a snapped coordinate plus size and velocity.
    localparam int CW = COORD_BITS + 3;
    localparam int SIZE_BITS = 10;
    localparam int VEL_BITS = 9;

    localparam logic signed [CW-1:0] ONE = CW'(1);
    localparam logic signed [VEL_BITS-1:0] VEL_ONE = VEL_BITS'(1);
    localparam logic signed [VEL_BITS-1:0] VEL_ZERO = '0;

    localparam logic signed [CW-1:0] SAT_HI = CW'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - ONE;

    localparam logic [2:0] CORNER_NONE = 3'd0;
    localparam logic [2:0] CORNER_TL   = 3'd1;
    localparam logic [2:0] CORNER_TR   = 3'd2;
    localparam logic [2:0] CORNER_BL   = 3'd3;
    localparam logic [2:0] CORNER_BR   = 3'd4;

    localparam logic REG_MOVER_WIDTH  = 1'b0;
    localparam logic REG_MOVER_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0]       x;
        logic signed [CW-1:0]       y;
        logic signed [VEL_BITS-1:0] vx;
        logic signed [VEL_BITS-1:0] vy;
        logic signed [CW-1:0]       px;
        logic signed [CW-1:0]       py;
        logic [SIZE_BITS-1:0]       pw;
        logic [SIZE_BITS-1:0]       ph;
        logic                       key;
        logic                       side;
        logic                       tb;
        logic                       jump;
        logic [2:0]                 corner;
    } item_t;

    function automatic logic signed [CW-1:0] ext_size(input logic [SIZE_BITS-1:0] v);
        return CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] ext_vel(input logic signed [VEL_BITS-1:0] v);
        return CW'(v);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[COORD_BITS-1:0];
    endfunction

endpackage

// File: rtl/sbcr_side.sv
module sbcr_side (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [9:0]            mover_width,
    input  logic [9:0]            mover_height,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sbcr_pkg::item_t       in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sbcr_pkg::item_t       out_item
);

    logic            valid_reg;
    sbcr_pkg::item_t item_reg;
    sbcr_pkg::item_t item_next;

    logic signed [sbcr_pkg::CW-1:0] mw, mh, x, y, vx, px, py, pw, ph;
    logic cross_y, hit_left, hit_right;

    always_comb begin
        mw = sbcr_pkg::ext_size(mover_width);
        mh = sbcr_pkg::ext_size(mover_height);
        x  = in_item.x;
        y  = in_item.y;
        vx = sbcr_pkg::ext_vel(in_item.vx);
        px = in_item.px;
        py = in_item.py;
        pw = sbcr_pkg::ext_size(in_item.pw);
        ph = sbcr_pkg::ext_size(in_item.ph);

        cross_y   = (y <= py + ph) && (y + mh >= py);
        hit_left  = cross_y && (x + mw < px) && (x + mw + vx >= px);
        // A left snap leaves the box left of the platform, so right cannot follow
        hit_right = cross_y && !(x + mw < px) && (x > px + pw) && (x + vx <= px + pw);

        item_next      = in_item;
        item_next.side = 1'b0;
        if (hit_left) begin
            item_next.x    = px - mw - sbcr_pkg::ONE;
            item_next.vx   = sbcr_pkg::VEL_ZERO;
            item_next.side = 1'b1;
        end else if (hit_right) begin
            item_next.x    = px + pw + sbcr_pkg::ONE;
            item_next.vx   = sbcr_pkg::VEL_ZERO;
            item_next.side = 1'b1;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/sbcr_topbot.sv
module sbcr_topbot (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [9:0]            mover_width,
    input  logic [9:0]            mover_height,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sbcr_pkg::item_t       in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sbcr_pkg::item_t       out_item
);

    logic            valid_reg;
    sbcr_pkg::item_t item_reg;
    sbcr_pkg::item_t item_next;

    logic signed [sbcr_pkg::CW-1:0] mw, mh, x, y, vy, px, py, pw, ph;
    logic cross_x, hit_top, hit_bot;

    always_comb begin
        mw = sbcr_pkg::ext_size(mover_width);
        mh = sbcr_pkg::ext_size(mover_height);
        x  = in_item.x;
        y  = in_item.y;
        vy = sbcr_pkg::ext_vel(in_item.vy);
        px = in_item.px;
        py = in_item.py;
        pw = sbcr_pkg::ext_size(in_item.pw);
        ph = sbcr_pkg::ext_size(in_item.ph);

        cross_x = (x + mw >= px) && (x <= px + pw);
        hit_top = cross_x && (y + mh < py) && (y + mh + vy >= py);
        // A top snap leaves the box above the platform, so bottom cannot follow
        hit_bot = cross_x && !(y + mh < py) && (y > py + ph) && (y + vy <= py + ph);

        item_next      = in_item;
        item_next.tb   = 1'b0;
        item_next.jump = 1'b0;
        if (hit_top) begin
            item_next.y    = py - mh - sbcr_pkg::ONE;
            item_next.vy   = sbcr_pkg::VEL_ONE;
            item_next.tb   = 1'b1;
            item_next.jump = !in_item.key;
        end else if (hit_bot) begin
            item_next.y  = py + ph + sbcr_pkg::ONE;
            item_next.vy = sbcr_pkg::VEL_ONE;
            item_next.tb = 1'b1;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/sbcr_corner.sv
module sbcr_corner (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [9:0]            mover_width,
    input  logic [9:0]            mover_height,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sbcr_pkg::item_t       in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sbcr_pkg::item_t       out_item
);

    logic            valid_reg;
    sbcr_pkg::item_t item_reg;
    sbcr_pkg::item_t item_next;

    logic signed [sbcr_pkg::CW-1:0] mw, mh, x, y, vx, vy, px, py, pw, ph;
    logic left, right, above, below;
    logic reach_l, reach_r, reach_t, reach_b;
    logic vx_pos, vx_neg, vy_pos, vy_neg;
    logic [2:0] code;

    always_comb begin
        mw = sbcr_pkg::ext_size(mover_width);
        mh = sbcr_pkg::ext_size(mover_height);
        x  = in_item.x;
        y  = in_item.y;
        vx = sbcr_pkg::ext_vel(in_item.vx);
        vy = sbcr_pkg::ext_vel(in_item.vy);
        px = in_item.px;
        py = in_item.py;
        pw = sbcr_pkg::ext_size(in_item.pw);
        ph = sbcr_pkg::ext_size(in_item.ph);

        left    = x + mw < px;
        right   = x > px + pw;
        above   = y + mh < py;
        below   = y > py + ph;
        reach_l = x + mw + vx >= px;
        reach_r = x + vx <= px + pw;
        reach_t = y + mh + vy >= py;
        reach_b = y + vy <= py + ph;
        vx_neg  = in_item.vx[sbcr_pkg::VEL_BITS-1];
        vy_neg  = in_item.vy[sbcr_pkg::VEL_BITS-1];
        vx_pos  = !vx_neg && (in_item.vx != sbcr_pkg::VEL_ZERO);
        vy_pos  = !vy_neg && (in_item.vy != sbcr_pkg::VEL_ZERO);

        if (left && above && vx_pos && vy_pos && reach_l && reach_t) begin
            code = sbcr_pkg::CORNER_TL;
        end else if (right && above && vx_neg && vy_pos && reach_r && reach_t) begin
            code = sbcr_pkg::CORNER_TR;
        end else if (left && below && vx_pos && vy_neg && reach_l && reach_b) begin
            code = sbcr_pkg::CORNER_BL;
        end else if (right && below && vx_neg && vy_neg && reach_r && reach_b) begin
            code = sbcr_pkg::CORNER_BR;
        end else begin
            code = sbcr_pkg::CORNER_NONE;
        end

        item_next        = in_item;
        item_next.corner = code;
        if (code != sbcr_pkg::CORNER_NONE) begin
            item_next.vx = sbcr_pkg::VEL_ZERO;
            item_next.vy = sbcr_pkg::VEL_ZERO;
            if (code == sbcr_pkg::CORNER_TL || code == sbcr_pkg::CORNER_BL) begin
                item_next.x = px - mw - sbcr_pkg::ONE;
            end else begin
                item_next.x = px + pw + sbcr_pkg::ONE;
            end
            // Top corners sit flush on the platform edge, no gap pixel
            if (code == sbcr_pkg::CORNER_TL || code == sbcr_pkg::CORNER_TR) begin
                item_next.y = py - mh;
            end else begin
                item_next.y = py + ph + sbcr_pkg::ONE;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/swept_box_collision_resolve_top.sv
// Swept box collision resolver: one request per cycle while the result channel does not
// stall, and each request passes through four register stages in a row (side checks,
// top/bottom checks, corner checks, saturated output register): the accepting edge
// loads the first stage and the request moves on whenever the next stage can take it. Each
// stage holds one request and takes a new one whenever it is empty or its content moves
// on, so the pipe fills behind a stalled result. mover_width and mover_height sit at APB
// byte addresses 0x0 and 0x4.
`include "assert_macros.svh"

module swept_box_collision_resolve_top (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [2:0]                                paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready,
    // request channel
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [sbcr_pkg::COORD_BITS-1:0]    s_mover_x,
    input  logic signed [sbcr_pkg::COORD_BITS-1:0]    s_mover_y,
    input  logic signed [8:0]                         s_mover_vx,
    input  logic signed [8:0]                         s_mover_vy,
    input  logic signed [sbcr_pkg::COORD_BITS-1:0]    s_plat_x,
    input  logic signed [sbcr_pkg::COORD_BITS-1:0]    s_plat_y,
    input  logic [9:0]                                s_plat_w,
    input  logic [9:0]                                s_plat_h,
    input  logic                                      s_jump_key_down,
    // result channel
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [sbcr_pkg::COORD_BITS-1:0]    m_new_x,
    output logic signed [sbcr_pkg::COORD_BITS-1:0]    m_new_y,
    output logic signed [8:0]                         m_new_vx,
    output logic signed [8:0]                         m_new_vy,
    output logic                                      m_side_hit,
    output logic                                      m_topbot_hit,
    output logic [2:0]                                m_corner_code,
    output logic                                      m_jump_ready
);

    logic [9:0] mover_width_reg;
    logic [9:0] mover_height_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mover_width_reg  <= 10'd32;
            mover_height_reg <= 10'd32;
        end else if (cfg_write) begin
            if (paddr[2] == sbcr_pkg::REG_MOVER_WIDTH) begin
                mover_width_reg <= pwdata[9:0];
            end else begin
                mover_height_reg <= pwdata[9:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == sbcr_pkg::REG_MOVER_WIDTH) begin
            prdata = {22'd0, mover_width_reg};
        end else begin
            prdata = {22'd0, mover_height_reg};
        end
    end

    sbcr_pkg::item_t in_item;
    sbcr_pkg::item_t side_item, tb_item, corner_item;
    logic side_valid, side_ready;
    logic tb_valid, tb_ready;
    logic corner_valid, corner_ready;

    always_comb begin
        in_item        = '0;
        in_item.x      = sbcr_pkg::CW'(s_mover_x);
        in_item.y      = sbcr_pkg::CW'(s_mover_y);
        in_item.vx     = s_mover_vx;
        in_item.vy     = s_mover_vy;
        in_item.px     = sbcr_pkg::CW'(s_plat_x);
        in_item.py     = sbcr_pkg::CW'(s_plat_y);
        in_item.pw     = s_plat_w;
        in_item.ph     = s_plat_h;
        in_item.key    = s_jump_key_down;
        in_item.corner = sbcr_pkg::CORNER_NONE;
    end

    sbcr_side u_side (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mover_width  (mover_width_reg),
        .mover_height (mover_height_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_item      (in_item),
        .out_valid    (side_valid),
        .out_ready    (side_ready),
        .out_item     (side_item)
    );

    sbcr_topbot u_topbot (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mover_width  (mover_width_reg),
        .mover_height (mover_height_reg),
        .in_valid     (side_valid),
        .in_ready     (side_ready),
        .in_item      (side_item),
        .out_valid    (tb_valid),
        .out_ready    (tb_ready),
        .out_item     (tb_item)
    );

    sbcr_corner u_corner (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mover_width  (mover_width_reg),
        .mover_height (mover_height_reg),
        .in_valid     (tb_valid),
        .in_ready     (tb_ready),
        .in_item      (tb_item),
        .out_valid    (corner_valid),
        .out_ready    (corner_ready),
        .out_item     (corner_item)
    );

    // Output register: saturate the position on the way in
    logic                                   out_valid_reg;
    logic signed [sbcr_pkg::COORD_BITS-1:0] new_x_reg, new_y_reg;
    logic signed [8:0]                      new_vx_reg, new_vy_reg;
    logic                                   side_hit_reg, topbot_hit_reg, jump_ready_reg;
    logic [2:0]                             corner_code_reg;

    assign corner_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (corner_ready) begin
            out_valid_reg <= corner_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (corner_ready && corner_valid) begin
            new_x_reg       <= sbcr_pkg::sat_coord(corner_item.x);
            new_y_reg       <= sbcr_pkg::sat_coord(corner_item.y);
            new_vx_reg      <= corner_item.vx;
            new_vy_reg      <= corner_item.vy;
            side_hit_reg    <= corner_item.side;
            topbot_hit_reg  <= corner_item.tb;
            corner_code_reg <= corner_item.corner;
            jump_ready_reg  <= corner_item.jump;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_new_x       = new_x_reg;
    assign m_new_y       = new_y_reg;
    assign m_new_vx      = new_vx_reg;
    assign m_new_vy      = new_vy_reg;
    assign m_side_hit    = side_hit_reg;
    assign m_topbot_hit  = topbot_hit_reg;
    assign m_corner_code = corner_code_reg;
    assign m_jump_ready  = jump_ready_reg;

    `ASSERT_NEXT(a_accept_fills_side, aclk, aresetn, s_valid && s_ready, side_valid)
    `ASSERT_NEXT(a_stall_holds_result, aclk, aresetn, m_valid && !m_ready,
                 m_valid && $stable(m_new_x) && $stable(m_corner_code))
    `ASSERT_IMPLY(a_jump_needs_landing, aclk, aresetn, m_valid && m_jump_ready, m_topbot_hit)
    `ASSERT_IMPLY(a_corner_stops_box, aclk, aresetn,
                  m_valid && (m_corner_code != sbcr_pkg::CORNER_NONE),
                  (m_new_vx == 9'sd0) && (m_new_vy == 9'sd0))

endmodule
